/* hw/rtl/worker_dispatch_queue_with_liveness_macros.svh */
// Assertion macros shared by the checker of the worker dispatch queue.
// Each macro takes a label, an antecedent and a consequent; clk_i and rst_ni must be in scope.
`ifndef WORKER_DISPATCH_QUEUE_WITH_LIVENESS_MACROS_SVH
`define WORKER_DISPATCH_QUEUE_WITH_LIVENESS_MACROS_SVH

// Same-cycle implication.
`define WDQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wdq assertion failed");

// Next-cycle implication.
`define WDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wdq assertion failed");

`endif

/* hw/rtl/wdq_pkg.sv */
// Package of the worker dispatch queue: widths, codes, cell types and a saturating adder.
// No dependencies; used by the top level, the cell and the checker.
`timescale 1ns / 1ps
`default_nettype none

package wdq_pkg;

  localparam int unsigned TIME_W          = 32;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned TAG_W           = 8;
  localparam int unsigned MAX_WORKERS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 32;
  localparam int unsigned RES_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [TIME_W-1:0] RST_LIVENESS = 32'd30000;
  localparam logic [TIME_W-1:0] RST_PERIOD   = 32'd10000;
  localparam logic [TIME_W-1:0] RST_TIMEOUT  = 32'd30000;

  typedef enum logic [2:0] {
    ACT_REQ   = 3'd0,
    ACT_READY = 3'd1,
    ACT_BEAT  = 3'd2,
    ACT_RESP  = 3'd3,
    ACT_TICK  = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    KIND_FWD     = 3'd0,
    KIND_HB      = 3'd1,
    KIND_RESP    = 3'd2,
    KIND_QUEUED  = 3'd3,
    KIND_DROP    = 3'd4,
    KIND_DUP     = 3'd5,
    KIND_UNKNOWN = 3'd6,
    KIND_ACK     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    REG_LIVENESS = 2'd0,
    REG_PERIOD   = 2'd1,
    REG_TIMEOUT  = 2'd2
  } reg_e;

  // One stored entry: an identity or tag, and a time word.
  typedef struct packed {
    logic [ID_W-1:0]   key;
    logic [TIME_W-1:0] word;
  } entry_t;

  // Control broadcast along a chain of cells.
  typedef struct packed {
    logic              shift;
    logic              wr;
    logic              refresh;
    logic [ID_W-1:0]   key;
    logic [TIME_W-1:0] word;
  } cell_ctl_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/worker_dispatch_queue_with_liveness.sv */
// Sequence: a transaction is taken in S_IDLE and executed in S_EXEC (and S_RESP2 for a
// response); its last result reaches the output register in S_FLUSH. A tick also walks the
// worker chain once in S_SCAN and removes timed-out requests from the front in S_DRAIN.
// A new input transaction is taken only after the previous one has run to its final flush.
// Reset: counters, time and configuration return to their reset values at once; cell contents
// are left undefined and are never read beyond the fill counts.
`timescale 1ns / 1ps
`default_nettype none

module worker_dispatch_queue_with_liveness #(
  parameter int unsigned MAX_WORKERS = wdq_pkg::MAX_WORKERS_DEF,
  parameter int unsigned QUEUE_DEPTH = wdq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // action[2:0], worker[10:3], client_tag[18:11]
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // out_worker[7:0], out_tag[15:8]
  output logic [2:0]       m_axis_tuser,   // kind[2:0]
  output logic             m_axis_tlast,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Widths of chain positions and fill counts.
  localparam int unsigned W_IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned W_CW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned Q_IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned Q_CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW   = wdq_pkg::TIME_W;
  localparam int unsigned IW   = wdq_pkg::ID_W;
  localparam int unsigned GW   = wdq_pkg::TAG_W;
  localparam int unsigned RW   = wdq_pkg::RES_W;

  // The sequencer takes one transaction at a time; each transaction runs to the final flush.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_RESP2 = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [TW-1:0] live_q, period_q, timeout_q;

  // Captured input transaction.
  wdq_pkg::act_e  act_q;
  logic [IW-1:0]  id_q;
  logic [GW-1:0]  tag_q;

  // Counters and time.
  logic [W_CW-1:0] rc_q, rc_d;
  logic [Q_CW-1:0] wc_q, wc_d;
  logic [W_CW-1:0] scan_q, scan_d;
  logic [TW-1:0]   now_q, now_d;
  logic [TW-1:0]   nb_q, nb_d;
  logic            beat_q, beat_d;
  logic [RW-1:0]   n_q;

  // Chains of cells: ready workers and waiting requests.
  wdq_pkg::entry_t   w_ent [MAX_WORKERS];
  logic              w_hit [MAX_WORKERS];
  wdq_pkg::cell_ctl_t w_ctl;
  logic [W_IW-1:0]   w_pos;
  wdq_pkg::entry_t   q_ent [QUEUE_DEPTH];
  wdq_pkg::cell_ctl_t q_ctl;
  logic [Q_IW-1:0]   q_pos;

  // One pending result is held back until the next one shows whether it is the last.
  logic               pend_v_q;
  wdq_pkg::kind_e     pend_kind_q;
  logic [IW-1:0]      pend_worker_q;
  logic [GW-1:0]      pend_tag_q;

  logic               out_v_q;
  wdq_pkg::kind_e     out_kind_q;
  logic [IW-1:0]      out_worker_q;
  logic [GW-1:0]      out_tag_q;
  logic               out_last_q;

  logic               emit, do_emit, flush, emit_ok, out_free, out_load;
  wdq_pkg::kind_e     e_kind;
  logic [IW-1:0]      e_worker;
  logic [GW-1:0]      e_tag;

  logic               known, rc_nz, rc_full, wc_nz, wc_full, in_acc, cfg_wr;
  logic [TW-1:0]      dl_new, now_inc, age;

  // --------------------------------------------------------------------------
  // Configuration port: writes complete in the access phase, reads are direct.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= wdq_pkg::RST_LIVENESS;
      period_q  <= wdq_pkg::RST_PERIOD;
      timeout_q <= wdq_pkg::RST_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        wdq_pkg::REG_LIVENESS: live_q    <= pwdata;
        wdq_pkg::REG_PERIOD:   period_q  <= pwdata;
        wdq_pkg::REG_TIMEOUT:  timeout_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      wdq_pkg::REG_LIVENESS: prdata = live_q;
      wdq_pkg::REG_PERIOD:   prdata = period_q;
      wdq_pkg::REG_TIMEOUT:  prdata = timeout_q;
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Cell chains. Each cell shifts towards the front when told to; the identity
  // match is gated by the fill count so that stale cells never hit.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_wcell
    wdq_pkg::entry_t nxt;
    if (i == MAX_WORKERS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = w_ent[i+1];
    end
    assign w_hit[i] = (w_ent[i].key == id_q) && (W_CW'(i) < rc_q);
    wdq_cell #(.IDX_W(W_IW), .INDEX(i)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (w_ctl),
      .pos_i  (w_pos),
      .hit_i  (w_hit[i]),
      .next_i (nxt),
      .ent_o  (w_ent[i])
    );
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_qcell
    wdq_pkg::entry_t nxt;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = q_ent[i+1];
    end
    wdq_cell #(.IDX_W(Q_IW), .INDEX(i)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (q_ctl),
      .pos_i  (q_pos),
      .hit_i  (1'b0),
      .next_i (nxt),
      .ent_o  (q_ent[i])
    );
  end

  always_comb begin
    known = 1'b0;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      known = known | w_hit[i];
    end
  end

  assign rc_nz   = (rc_q != '0);
  assign rc_full = (rc_q == W_CW'(MAX_WORKERS));
  assign wc_nz   = (wc_q != '0);
  assign wc_full = (wc_q == Q_CW'(QUEUE_DEPTH));
  assign dl_new  = wdq_pkg::sat_add(now_q, live_q);
  assign now_inc = wdq_pkg::sat_add(now_q, TW'(1));
  assign age     = now_q - q_ent[0].word;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  assign emit_ok       = !pend_v_q || out_free;

  // --------------------------------------------------------------------------
  // Sequencer. Every state that produces a result waits while the pending slot
  // cannot be passed on; in that case nothing else changes either.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    rc_d     = rc_q;
    wc_d     = wc_q;
    scan_d   = scan_q;
    now_d    = now_q;
    nb_d     = nb_q;
    beat_d   = beat_q;
    w_ctl    = '{shift: 1'b0, wr: 1'b0, refresh: 1'b0, key: id_q, word: dl_new};
    w_pos    = '0;
    q_ctl    = '{shift: 1'b0, wr: 1'b0, refresh: 1'b0, key: tag_q, word: now_q};
    q_pos    = '0;
    emit     = 1'b0;
    flush    = 1'b0;
    e_kind   = wdq_pkg::KIND_FWD;
    e_worker = '0;
    e_tag    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_FLUSH;
        unique case (act_q)
          wdq_pkg::ACT_REQ: begin
            emit  = 1'b1;
            e_tag = tag_q;
            if (rc_nz) begin
              e_kind      = wdq_pkg::KIND_FWD;
              e_worker    = w_ent[0].key;
              w_ctl.shift = 1'b1;
              rc_d        = rc_q - 1'b1;
            end else if (!wc_full) begin
              e_kind   = wdq_pkg::KIND_QUEUED;
              q_ctl.wr = 1'b1;
              q_pos    = wc_q[Q_IW-1:0];
              wc_d     = wc_q + 1'b1;
            end else begin
              e_kind = wdq_pkg::KIND_DROP;
            end
          end
          wdq_pkg::ACT_READY: begin
            emit     = 1'b1;
            e_worker = id_q;
            if (known) begin
              e_kind = wdq_pkg::KIND_DUP;
            end else if (wc_nz) begin
              // The oldest waiting request goes to the front worker; the new
              // worker joins the back, or serves it directly on an empty list.
              e_kind      = wdq_pkg::KIND_FWD;
              e_tag       = q_ent[0].key;
              q_ctl.shift = 1'b1;
              wc_d        = wc_q - 1'b1;
              if (rc_nz) begin
                e_worker    = w_ent[0].key;
                w_ctl.shift = 1'b1;
                w_ctl.wr    = 1'b1;
                w_pos       = W_IW'(rc_q - 1'b1);
              end
            end else if (rc_full) begin
              e_kind = wdq_pkg::KIND_DROP;
            end else begin
              e_kind   = wdq_pkg::KIND_ACK;
              w_ctl.wr = 1'b1;
              w_pos    = rc_q[W_IW-1:0];
              rc_d     = rc_q + 1'b1;
            end
          end
          wdq_pkg::ACT_BEAT: begin
            emit     = 1'b1;
            e_worker = id_q;
            if (known) begin
              e_kind        = wdq_pkg::KIND_ACK;
              w_ctl.refresh = 1'b1;
            end else begin
              e_kind = wdq_pkg::KIND_UNKNOWN;
            end
          end
          wdq_pkg::ACT_RESP: begin
            emit     = 1'b1;
            e_kind   = wdq_pkg::KIND_RESP;
            e_worker = id_q;
            e_tag    = tag_q;
            state_d  = S_RESP2;
          end
          wdq_pkg::ACT_TICK: begin
            now_d  = now_inc;
            beat_d = (now_inc > nb_q);
            if (now_inc > nb_q) begin
              nb_d = wdq_pkg::sat_add(now_inc, period_q);
            end
            scan_d  = rc_q;
            state_d = rc_nz ? S_SCAN : S_DRAIN;
          end
          default: ;
        endcase
      end

      S_RESP2: begin
        state_d  = S_FLUSH;
        e_worker = id_q;
        if (known) begin
          emit   = 1'b1;
          e_kind = wdq_pkg::KIND_DUP;
        end else if (rc_full) begin
          emit   = 1'b1;
          e_kind = wdq_pkg::KIND_DROP;
        end else begin
          w_ctl.wr = 1'b1;
          w_pos    = rc_q[W_IW-1:0];
          rc_d     = rc_q + 1'b1;
        end
      end

      S_SCAN: begin
        // The front worker leaves the chain; a live one is written back at the
        // tail, so a full pass keeps the order and drops the expired ones.
        emit        = beat_q;
        e_kind      = wdq_pkg::KIND_HB;
        e_worker    = w_ent[0].key;
        w_ctl.shift = 1'b1;
        w_ctl.key   = w_ent[0].key;
        w_ctl.word  = w_ent[0].word;
        if (w_ent[0].word >= now_q) begin
          w_ctl.wr = 1'b1;
          w_pos    = W_IW'(rc_q - 1'b1);
        end else begin
          rc_d = rc_q - 1'b1;
        end
        scan_d = scan_q - 1'b1;
        if (scan_q == W_CW'(1)) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (wc_nz && (age > timeout_q)) begin
          emit        = 1'b1;
          e_kind      = wdq_pkg::KIND_ACK;
          e_tag       = q_ent[0].key;
          q_ctl.shift = 1'b1;
          wc_d        = wc_q - 1'b1;
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          flush   = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (emit && !emit_ok) begin
      state_d       = state_q;
      rc_d          = rc_q;
      wc_d          = wc_q;
      scan_d        = scan_q;
      w_ctl.shift   = 1'b0;
      w_ctl.wr      = 1'b0;
      w_ctl.refresh = 1'b0;
      q_ctl.shift   = 1'b0;
      q_ctl.wr      = 1'b0;
      emit          = 1'b0;
    end
  end

  // Results past the per-transaction limit are not reported.
  assign do_emit  = emit && (n_q < RW'(wdq_pkg::MAX_RESULTS));
  assign out_load = flush || (do_emit && pend_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rc_q     <= '0;
      wc_q     <= '0;
      scan_q   <= '0;
      now_q    <= '0;
      nb_q     <= wdq_pkg::RST_PERIOD;
      beat_q   <= 1'b0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      act_q    <= wdq_pkg::ACT_REQ;
    end else begin
      state_q <= state_d;
      rc_q    <= rc_d;
      wc_q    <= wc_d;
      scan_q  <= scan_d;
      now_q   <= now_d;
      nb_q    <= nb_d;
      beat_q  <= beat_d;
      if (in_acc) begin
        act_q <= wdq_pkg::act_e'(s_axis_tdata[2:0]);
        n_q   <= '0;
      end else if (do_emit) begin
        n_q <= n_q + 1'b1;
      end
      if (do_emit) begin
        pend_v_q <= 1'b1;
      end else if (flush) begin
        pend_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q  <= s_axis_tdata[10:3];
      tag_q <= s_axis_tdata[18:11];
    end
    if (out_load) begin
      out_kind_q   <= pend_kind_q;
      out_worker_q <= pend_worker_q;
      out_tag_q    <= pend_tag_q;
      out_last_q   <= flush;
    end
    if (do_emit) begin
      pend_kind_q   <= e_kind;
      pend_worker_q <= e_worker;
      pend_tag_q    <= e_tag;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_tag_q, out_worker_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/wdq_cell.sv */
// One cell of a shifting FIFO chain: holds an entry, shifts from its neighbour,
// takes a write at its own position and refreshes its time word on a match. Uses wdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wdq_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned INDEX = 0
) (
  input  wire logic               clk_i,
  input  wire wdq_pkg::cell_ctl_t ctl_i,
  input  wire logic [IDX_W-1:0]   pos_i,
  input  wire logic               hit_i,
  input  wire wdq_pkg::entry_t    next_i,
  output wdq_pkg::entry_t         ent_o
);

  wdq_pkg::entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.shift) begin
      ent_d = next_i;
    end
    if (ctl_i.refresh && hit_i) begin
      ent_d.word = ctl_i.word;
    end
    // A write at this position wins over the shift.
    if (ctl_i.wr && (pos_i == IDX_W'(INDEX))) begin
      ent_d.key  = ctl_i.key;
      ent_d.word = ctl_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

/* hw/rtl/wdq_checker.sv */
// Port-level checker of the worker dispatch queue, bound to the top level.
// Depends on wdq_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "worker_dispatch_queue_with_liveness_macros.svh"

module wdq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // A stalled result keeps its contents.
  `WDQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // One transaction is worked on at a time.
  `WDQ_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Heartbeats carry no client tag.
  `WDQ_ASSERT_IMP(a_hb_no_tag, m_axis_tvalid && (m_axis_tuser == wdq_pkg::KIND_HB), m_axis_tdata[15:8] == 8'd0)

  // Queued requests name no worker.
  `WDQ_ASSERT_IMP(a_queued_no_worker, m_axis_tvalid && (m_axis_tuser == wdq_pkg::KIND_QUEUED), m_axis_tdata[7:0] == 8'd0)

endmodule

bind worker_dispatch_queue_with_liveness wdq_checker u_wdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
